@@ rtl/core/ip_source_learning_table_top_assert.svh @@
// assertion macros for the ip source learning table top level
// expects clk and rst in the scope of the including module
`ifndef IP_SOURCE_LEARNING_TABLE_TOP_ASSERT_SVH
`define IP_SOURCE_LEARNING_TABLE_TOP_ASSERT_SVH

// checked only outside reset
`define ISL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form, checked only outside reset
`define ISL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/isl_pkg.sv @@
// shared types, constants and the hash function of the ip source learning table
// no dependencies
package isl_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86dd;
  localparam logic [7:0]  VERSION_IPV4   = 8'h45;
  localparam logic [7:0]  VERSION_IPV6   = 8'h60;

  // largest weighted byte sum is 255 * 329, fits in 17 bits
  localparam int unsigned HASH_SUM_W = 17;

  localparam logic [5:0] WEIGHT [16] = '{
    6'd1, 6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17,
    6'd19, 6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47
  };

  typedef enum logic [1:0] {
    ST_IGNORED = 2'd0,
    ST_KNOWN   = 2'd1,
    ST_LEARNED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_HASH,
    CS_RECIP,
    CS_MOD,
    CS_PROBE
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic hash;
    logic recip;
    logic index;
    logic step;
    logic clear;
    logic write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic last;
    logic learn;
  } sts_t;

  // prime-weighted byte sum, byte 0 most significant
  function automatic logic [HASH_SUM_W-1:0] weighted_sum(
    input logic [63:0] hi,
    input logic [63:0] lo,
    input logic        v6
  );
    logic [HASH_SUM_W-1:0] acc;
    acc = '0;
    if (v6) begin
      for (int k = 0; k < 8; k++) begin
        acc = acc + HASH_SUM_W'(hi[63-8*k -: 8]) * HASH_SUM_W'(WEIGHT[k]);
        acc = acc + HASH_SUM_W'(lo[63-8*k -: 8]) * HASH_SUM_W'(WEIGHT[8+k]);
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        acc = acc + HASH_SUM_W'(lo[31-8*k -: 8]) * HASH_SUM_W'(WEIGHT[k]);
      end
    end
    return acc;
  endfunction

endpackage

@@ rtl/core/isl_ifs.sv @@
// frame and result channel interfaces of the ip source learning table
// depends on nothing
interface isl_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] ethertype;
  logic [7:0]  version_byte;
  logic [63:0] source_high;
  logic [63:0] source_low;

  modport source (output valid, ethertype, version_byte, source_high, source_low,
                  input ready);
  modport sink (input valid, ethertype, version_byte, source_high, source_low,
                output ready);
endinterface

interface isl_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] slot;
  logic       family_v6;

  modport source (output valid, status, slot, family_v6, input ready);
  modport sink (input valid, status, slot, family_v6, output ready);
endinterface

@@ rtl/core/isl_ctrl.sv @@
// controller of the ip source learning table: clear pass, hash sequence, probe loop
// depends on isl_pkg
module isl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  isl_pkg::sts_t sts,
  output isl_pkg::cmd_t cmd
);

  isl_pkg::ctl_state_t state, state_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= isl_pkg::CS_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      isl_pkg::CS_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.last) begin
          state_next = isl_pkg::CS_IDLE;
        end
      end
      isl_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = isl_pkg::CS_HASH;
        end
      end
      isl_pkg::CS_HASH: begin
        cmd.hash   = 1'b1;
        state_next = isl_pkg::CS_RECIP;
      end
      isl_pkg::CS_RECIP: begin
        cmd.recip  = 1'b1;
        state_next = isl_pkg::CS_MOD;
      end
      isl_pkg::CS_MOD: begin
        cmd.index  = 1'b1;
        state_next = isl_pkg::CS_PROBE;
      end
      isl_pkg::CS_PROBE: begin
        if (!sts.done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          // table write and result load share the cycle the slot is settled
          cmd.emit   = 1'b1;
          cmd.write  = sts.learn;
          state_next = isl_pkg::CS_IDLE;
        end
      end
      default: begin
        state_next = isl_pkg::CS_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/core/isl_dp.sv @@
// datapath of the ip source learning table: hash, modulo, both tables, result register
// depends on isl_pkg
module isl_dp #(
  parameter int unsigned TABLE_ENTRIES = isl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  isl_pkg::cmd_t cmd,
  output isl_pkg::sts_t sts,
  input  logic          learning_enable,
  input  logic [15:0]   ethertype,
  input  logic [7:0]    version_byte,
  input  logic [63:0]   source_high,
  input  logic [63:0]   source_low,
  output logic [1:0]    status,
  output logic [7:0]    slot,
  output logic          family_v6
);

  localparam int unsigned IDX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SUM_W       = isl_pkg::HASH_SUM_W;
  localparam int unsigned RECIP_SHIFT = 34;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam int unsigned BACK_W      = SUM_W + 13;
  // floor reciprocal: quotient comes out exact or one short
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [SUM_W-1:0] MODULUS  = SUM_W'(TABLE_ENTRIES);

  logic [31:0]  v4_mem [TABLE_ENTRIES];
  logic [127:0] v6_mem [TABLE_ENTRIES];
  logic [31:0]  v4_rd;
  logic [127:0] v6_rd;

  logic              fam;
  logic              ignore;
  logic [63:0]       src_hi;
  logic [63:0]       src_lo;
  logic [SUM_W-1:0]  hash_sum;
  logic [SUM_W-1:0]  quot;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  cnt;

  logic              is_v4;
  logic              is_v6;
  logic [PROD_W-1:0] prod;
  logic [BACK_W-1:0] back;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  rem_fix;
  logic [IDX_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  rd_addr;
  logic              hit;
  logic              empty;
  logic              last;

  assign is_v4 = learning_enable && ethertype == isl_pkg::ETHERTYPE_IPV4 &&
                 version_byte == isl_pkg::VERSION_IPV4;
  assign is_v6 = learning_enable && ethertype == isl_pkg::ETHERTYPE_IPV6 &&
                 version_byte == isl_pkg::VERSION_IPV6;

  assign prod    = PROD_W'(hash_sum) * PROD_W'(RECIP);
  assign back    = BACK_W'(quot) * BACK_W'(TABLE_ENTRIES);
  assign rem     = hash_sum - SUM_W'(back);
  assign rem_fix = (rem >= MODULUS) ? rem - MODULUS : rem;

  assign idx_inc = (idx == IDX_LAST) ? '0 : idx + 1'b1;
  assign last    = (cnt == IDX_LAST);

  always_comb begin
    rd_addr = idx;
    if (cmd.index) begin
      rd_addr = IDX_W'(rem_fix);
    end else if (cmd.step) begin
      rd_addr = idx_inc;
    end
  end

  // equality first, so an all-zero source matches the first empty slot
  assign hit   = fam ? (v6_rd == {src_hi, src_lo}) : (v4_rd == src_lo[31:0]);
  assign empty = fam ? (v6_rd == '0) : (v4_rd == '0);

  assign sts.last  = last;
  assign sts.done  = ignore || hit || empty || last;
  assign sts.learn = !ignore && !hit && empty;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fam    <= is_v6;
      ignore <= !(is_v4 || is_v6);
      src_hi <= source_high;
      src_lo <= source_low;
    end
    if (cmd.hash) begin
      hash_sum <= isl_pkg::weighted_sum(src_hi, src_lo, fam);
    end
    if (cmd.recip) begin
      quot <= SUM_W'(prod >> RECIP_SHIFT);
    end
    if (cmd.emit) begin
      family_v6 <= fam && !ignore;
      if (ignore) begin
        status <= isl_pkg::ST_IGNORED;
        slot   <= '0;
      end else if (hit) begin
        status <= isl_pkg::ST_KNOWN;
        slot   <= 8'(idx);
      end else if (empty) begin
        status <= isl_pkg::ST_LEARNED;
        slot   <= 8'(idx);
      end else begin
        status <= isl_pkg::ST_FULL;
        slot   <= '0;
      end
    end
  end

  // idx doubles as the clear pass address, so it is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      cnt <= '0;
    end else if (cmd.index) begin
      idx <= IDX_W'(rem_fix);
      cnt <= '0;
    end else if (cmd.step || cmd.clear) begin
      idx <= idx_inc;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      v4_mem[idx] <= '0;
    end else if (cmd.write && !fam) begin
      v4_mem[idx] <= src_lo[31:0];
    end
    v4_rd <= v4_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      v6_mem[idx] <= '0;
    end else if (cmd.write && fam) begin
      v6_mem[idx] <= {src_hi, src_lo};
    end
    v6_rd <= v6_mem[rd_addr];
  end

endmodule

@@ rtl/core/ip_source_learning_table_top.sv @@
// channel      | direction | payload
// frame        | in        | ethertype, version_byte, source_high, source_low
// result       | out       | status, slot, family_v6
// cfg_we/wdata | in        | learning_enable, write only
//
// an item runs load, hash, recip and mod, then probes 1 to TABLE_ENTRIES slots through
// the single registered read port of each family table; ignored frames stop at the first probe
// after reset a clear pass over all TABLE_ENTRIES slots runs before the first frame is taken
// a stalled result holds the probe loop; the next frame is taken while a result waits
// depends on isl_pkg, isl_ifs, isl_ctrl, isl_dp and the assertion macro header
module ip_source_learning_table_top #(
  parameter int unsigned TABLE_ENTRIES = isl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  isl_frame_if.sink    frame,
  isl_result_if.source result
);

  logic          learning_enable;
  isl_pkg::cmd_t cmd;
  isl_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_enable <= 1'b0;
    end else if (cfg_we) begin
      learning_enable <= cfg_wdata;
    end
  end

  isl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  isl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .learning_enable (learning_enable),
    .ethertype       (frame.ethertype),
    .version_byte    (frame.version_byte),
    .source_high     (frame.source_high),
    .source_low      (frame.source_low),
    .status          (result.status),
    .slot            (result.slot),
    .family_v6       (result.family_v6)
  );

`include "ip_source_learning_table_top_assert.svh"

  `ISL_ASSERT_IMPLY(a_ignored_clean, result.valid && result.status == isl_pkg::ST_IGNORED, result.slot == 8'd0 && !result.family_v6, "ignored result carries slot or family")
  `ISL_ASSERT_IMPLY(a_full_slot_zero, result.valid && result.status == isl_pkg::ST_FULL, result.slot == 8'd0, "full result carries a slot")
  `ISL_ASSERT_IMPLY(a_no_take_after_reset, $past(rst), !frame.ready, "frame taken before the clear pass")
  `ISL_ASSERT(a_write_with_emit, cmd.write |-> cmd.emit && !cmd.clear, "table write outside result load")

endmodule
